FILE: hw/rtl/csvt_pkg.sv
// Shared types and constants for the CSV stream tokenizer.
package csvt_pkg;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;

    typedef enum logic [1:0] {
        MODE_PLAIN   = 2'd0,
        MODE_QUOTED  = 2'd1,
        MODE_PENDING = 2'd2,
        MODE_CLOSED  = 2'd3
    } parse_mode_t;

    typedef enum logic [1:0] {
        EV_BYTE  = 2'd0,
        EV_FIELD = 2'd1,
        EV_ROW   = 2'd2,
        EV_ERROR = 2'd3
    } event_kind_t;

    typedef enum logic [1:0] {
        ERR_AFTER_QUOTE  = 2'd0,
        ERR_STRAY_QUOTE  = 2'd1,
        ERR_UNTERMINATED = 2'd2,
        ERR_NONE         = 2'd3
    } error_code_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_input;
    } in_item_t;

    typedef struct packed {
        logic        valid;
        event_kind_t event_kind;
        logic [7:0]  char_out;
        logic [1:0]  error_code;
    } result_t;

    typedef struct packed {
        parse_mode_t parse_mode;
        logic        field_is_empty;
        logic        row_has_fields;
        logic        swallow_line_feed;
        logic        error_latched;
    } parse_state_t;

endpackage

FILE: hw/rtl/csvt_in_stage.sv
// Input register stage of the CSV stream tokenizer.
module csvt_in_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  csvt_pkg::in_item_t s_item,
    input  logic              advance,
    output logic              item_valid,
    output csvt_pkg::in_item_t item
);
    import csvt_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    assign s_tready   = !valid_reg || advance;
    assign valid_next = (s_tvalid && s_tready) ? 1'b1 : (advance ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

FILE: hw/rtl/csvt_core.sv
// Parser state and per-item tokenizing logic.
module csvt_core (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  step_en,
    input  csvt_pkg::in_item_t    item,
    output csvt_pkg::result_t     res,
    output csvt_pkg::parse_state_t status
);
    import csvt_pkg::*;

    parse_state_t st_reg;
    parse_state_t st_next;

    localparam parse_state_t ST_RESET = '{
        parse_mode:        MODE_PLAIN,
        field_is_empty:    1'b1,
        row_has_fields:    1'b0,
        swallow_line_feed: 1'b0,
        error_latched:     1'b0
    };

    always_comb begin
        logic       after_quote;
        logic [7:0] c;
        logic       is_nl;
        c           = item.char_code;
        is_nl       = (c == CH_LF) || (c == CH_CR);
        after_quote = 1'b0;
        st_next     = st_reg;
        res.valid      = 1'b0;
        res.event_kind = EV_BYTE;
        res.char_out   = 8'd0;
        res.error_code = ERR_AFTER_QUOTE;

        if (item.end_of_input) begin
            if (!st_reg.error_latched) begin
                if (st_reg.parse_mode == MODE_QUOTED) begin
                    res.valid      = 1'b1;
                    res.event_kind = EV_ERROR;
                    res.error_code = ERR_UNTERMINATED;
                end else if (st_reg.parse_mode != MODE_PLAIN || !st_reg.field_is_empty
                             || st_reg.row_has_fields) begin
                    res.valid      = 1'b1;
                    res.event_kind = EV_ROW;
                end
            end
            st_next = ST_RESET;
        end else if (!st_reg.error_latched) begin
            st_next.swallow_line_feed = 1'b0;
            if (!(st_reg.swallow_line_feed && c == CH_LF)) begin
                case (st_reg.parse_mode)
                    MODE_QUOTED: begin
                        if (c == CH_QUOTE) begin
                            st_next.parse_mode = MODE_PENDING;
                        end else begin
                            st_next.field_is_empty = 1'b0;
                            res.valid    = 1'b1;
                            res.char_out = c;
                        end
                    end
                    MODE_PENDING: begin
                        if (c == CH_QUOTE) begin
                            st_next.parse_mode     = MODE_QUOTED;
                            st_next.field_is_empty = 1'b0;
                            res.valid    = 1'b1;
                            res.char_out = CH_QUOTE;
                        end else begin
                            after_quote = 1'b1;
                        end
                    end
                    MODE_CLOSED: begin
                        after_quote = 1'b1;
                    end
                    default: begin
                        if (c == CH_QUOTE && st_reg.field_is_empty) begin
                            st_next.parse_mode = MODE_QUOTED;
                        end else if (c == CH_COMMA) begin
                            st_next.field_is_empty = 1'b1;
                            st_next.row_has_fields = 1'b1;
                            res.valid      = 1'b1;
                            res.event_kind = EV_FIELD;
                        end else if (is_nl) begin
                            st_next.field_is_empty    = 1'b1;
                            st_next.row_has_fields    = 1'b0;
                            st_next.swallow_line_feed = (c == CH_CR);
                            res.valid      = 1'b1;
                            res.event_kind = EV_ROW;
                        end else if (c == CH_QUOTE) begin
                            st_next.error_latched = 1'b1;
                            res.valid      = 1'b1;
                            res.event_kind = EV_ERROR;
                            res.error_code = ERR_STRAY_QUOTE;
                        end else begin
                            st_next.field_is_empty = 1'b0;
                            res.valid    = 1'b1;
                            res.char_out = c;
                        end
                    end
                endcase

                if (after_quote) begin
                    if (c == CH_COMMA) begin
                        st_next.parse_mode     = MODE_PLAIN;
                        st_next.field_is_empty = 1'b1;
                        st_next.row_has_fields = 1'b1;
                        res.valid      = 1'b1;
                        res.event_kind = EV_FIELD;
                    end else if (is_nl) begin
                        st_next.parse_mode        = MODE_PLAIN;
                        st_next.field_is_empty    = 1'b1;
                        st_next.row_has_fields    = 1'b0;
                        st_next.swallow_line_feed = (c == CH_CR);
                        res.valid      = 1'b1;
                        res.event_kind = EV_ROW;
                    end else begin
                        st_next.parse_mode    = MODE_CLOSED;
                        st_next.error_latched = 1'b1;
                        res.valid      = 1'b1;
                        res.event_kind = EV_ERROR;
                        res.error_code = ERR_AFTER_QUOTE;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_RESET;
        end else if (step_en) begin
            st_reg <= st_next;
        end
    end

    assign status = st_reg;

endmodule

FILE: hw/rtl/csv_stream_tokenizer.sv
// Top level of the CSV stream tokenizer: input stage, parser core, result register.
//
// Input channel (s_): one byte per item in s_tdata[7:0]; s_tlast high marks end of
// input, which flushes the last row or reports an unterminated quote and then
// clears all parser state (s_tdata is ignored on that item).
// Result channel (m_): m_tuser is the event kind (content byte, end of field,
// end of field and row, error); m_tdata carries the content byte and error code.
// Items that cause no event (opening quote, swallowed LF, bytes after an error)
// are consumed without a result.
// A result passes through the input register and then the result register to m_.
// Throughput: one item per cycle while the receiver does not stall; the parser
// state update is a single combinational step between the two registers.
// When the receiver stalls, the result register holds and the input register
// stops advancing; s_tready drops once both are full.
// Reset (aresetn low, synchronous) empties both registers and returns the
// parser to the start of an unquoted, empty field.
module csv_stream_tokenizer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic        s_tlast,   // end_of_input
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] char_out, [9:8] error_code, [15:10] zero
    output logic [1:0]  m_tuser    // [1:0] event_kind
);
    import csvt_pkg::*;

    in_item_t     s_item;
    in_item_t     item;
    logic         item_valid;
    logic         advance;
    result_t      res;
    parse_state_t status;

    logic         out_valid_reg;
    logic         out_valid_next;
    result_t      out_reg;

    assign s_item.char_code    = s_tdata;
    assign s_item.end_of_input = s_tlast;

    assign advance = item_valid && (!out_valid_reg || m_tready);

    csvt_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    csvt_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .item    (item),
        .res     (res),
        .status  (status)
    );

    always_comb begin
        out_valid_next = out_valid_reg;
        if (m_tvalid && m_tready) begin
            out_valid_next = 1'b0;
        end
        if (advance && res.valid) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && res.valid) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.event_kind;
    assign m_tdata  = {6'd0, out_reg.error_code, out_reg.char_out};

    a_no_event_after_error: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && !item.end_of_input && status.error_latched |-> !res.valid)
        else $error("event produced while error is latched");

    a_end_clears_state: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && item.end_of_input |=> status.parse_mode == MODE_PLAIN
            && status.field_is_empty && !status.row_has_fields && !status.error_latched)
        else $error("end of input did not clear parser state");

    a_error_code_only_on_error: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != EV_ERROR |-> m_tdata[9:8] == 2'd0)
        else $error("error code set on a non-error event");

    a_char_only_on_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != EV_BYTE |-> m_tdata[7:0] == 8'd0)
        else $error("character set on a non-byte event");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !(advance && res.valid))
        else $error("pending result overwritten");

endmodule

FILE: tb/sv/csv_stream_tokenizer_tb.sv
// Self-checking testbench for the CSV stream tokenizer: directed and random byte streams.
module csv_stream_tokenizer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import csvt_pkg::*;

    localparam int ITEM_TARGET = 650;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_LIMIT = 2000;
    localparam int SHOW_LIMIT  = 10;

    typedef struct packed {
        event_kind_t kind;
        logic [7:0]  ch;
        logic [1:0]  code;
    } token_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;

    token_t pending_tokens[$];

    parse_mode_t mode_q        = MODE_PLAIN;
    bit          field_empty_q = 1'b1;
    bit          row_open_q    = 1'b0;
    bit          skip_lf_q     = 1'b0;
    bit          error_q       = 1'b0;

    bit src_idle_en  = 1'b1;
    bit sink_idle_en = 1'b1;
    bit hold_req     = 1'b0;
    bit hold_ack     = 1'b0;
    int hold_cnt     = 0;

    int items_sent     = 0;
    int events_checked = 0;
    int fail_count     = 0;
    int kind_count[4]  = '{default: 0};

    csv_stream_tokenizer u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 aclk = ~aclk;

    task automatic report_fail(input string what);
        fail_count++;
        if (fail_count <= SHOW_LIMIT) begin
            $display("[%0t] %s", $realtime, what);
        end
    endtask

    task automatic push_token(input event_kind_t kind, input logic [7:0] ch,
                              input logic [1:0] code);
        token_t tok;
        tok.kind = kind;
        tok.ch   = (kind == EV_BYTE) ? ch : 8'h00;
        tok.code = (kind == EV_ERROR) ? code : 2'd0;
        pending_tokens = {pending_tokens, tok};
    endtask

    task automatic clear_parser();
        mode_q        = MODE_PLAIN;
        field_empty_q = 1'b1;
        row_open_q    = 1'b0;
        skip_lf_q     = 1'b0;
        error_q       = 1'b0;
    endtask

    task automatic close_field();
        mode_q        = MODE_PLAIN;
        field_empty_q = 1'b1;
        row_open_q    = 1'b1;
        push_token(EV_FIELD, 8'h00, 2'd0);
    endtask

    task automatic close_row(input logic [7:0] ch);
        mode_q        = MODE_PLAIN;
        field_empty_q = 1'b1;
        row_open_q    = 1'b0;
        skip_lf_q     = (ch == CH_CR);
        push_token(EV_ROW, 8'h00, 2'd0);
    endtask

    // Advance the expected tokenizer by one accepted item.
    task automatic tokenize_byte(input logic [7:0] ch, input logic fin);
        if (fin) begin
            if (!error_q) begin
                if (mode_q == MODE_QUOTED) begin
                    push_token(EV_ERROR, 8'h00, ERR_UNTERMINATED);
                end else if (mode_q != MODE_PLAIN || !field_empty_q || row_open_q) begin
                    push_token(EV_ROW, 8'h00, 2'd0);
                end
            end
            clear_parser();
            return;
        end
        if (error_q) return;
        if (skip_lf_q) begin
            skip_lf_q = 1'b0;
            if (ch == CH_LF) return;
        end
        case (mode_q)
            MODE_QUOTED: begin
                if (ch == CH_QUOTE) begin
                    mode_q = MODE_PENDING;
                end else begin
                    field_empty_q = 1'b0;
                    push_token(EV_BYTE, ch, 2'd0);
                end
            end
            MODE_PENDING, MODE_CLOSED: begin
                if (mode_q == MODE_PENDING && ch == CH_QUOTE) begin
                    mode_q        = MODE_QUOTED;
                    field_empty_q = 1'b0;
                    push_token(EV_BYTE, CH_QUOTE, 2'd0);
                end else if (ch == CH_COMMA) begin
                    close_field();
                end else if (ch == CH_LF || ch == CH_CR) begin
                    close_row(ch);
                end else begin
                    mode_q  = MODE_CLOSED;
                    error_q = 1'b1;
                    push_token(EV_ERROR, 8'h00, ERR_AFTER_QUOTE);
                end
            end
            default: begin
                if (ch == CH_QUOTE && field_empty_q) begin
                    mode_q = MODE_QUOTED;
                end else if (ch == CH_COMMA) begin
                    close_field();
                end else if (ch == CH_LF || ch == CH_CR) begin
                    close_row(ch);
                end else if (ch == CH_QUOTE) begin
                    error_q = 1'b1;
                    push_token(EV_ERROR, 8'h00, ERR_STRAY_QUOTE);
                end else begin
                    field_empty_q = 1'b0;
                    push_token(EV_BYTE, ch, 2'd0);
                end
            end
        endcase
    endtask

    task automatic send_item(input logic [7:0] ch, input logic fin);
        if (src_idle_en && $urandom_range(0, 99) < 25) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tlast  <= fin;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
        tokenize_byte(ch, fin);
    endtask

    task automatic send_end();
        send_item(8'($urandom), 1'b1);
    endtask

    function automatic logic [7:0] plain_byte();
        logic [7:0] ch;
        do begin
            ch = 8'($urandom);
        end while (ch == CH_QUOTE || ch == CH_COMMA || ch == CH_CR || ch == CH_LF);
        return ch;
    endfunction

    function automatic logic [7:0] any_byte();
        case ($urandom_range(0, 7))
            0:       return CH_QUOTE;
            1:       return CH_COMMA;
            2:       return CH_CR;
            3:       return CH_LF;
            default: return 8'($urandom);
        endcase
    endfunction

    // One well-formed row of plain, quoted and empty fields.
    task automatic send_record();
        int         n_fields;
        int         len;
        logic [7:0] ch;
        n_fields = $urandom_range(1, 4);
        for (int f = 0; f < n_fields; f++) begin
            if (f > 0) send_item(CH_COMMA, 1'b0);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: begin
                    len = $urandom_range(1, 5);
                    repeat (len) send_item(plain_byte(), 1'b0);
                end
                5, 6, 7, 8: begin
                    send_item(CH_QUOTE, 1'b0);
                    len = $urandom_range(0, 6);
                    repeat (len) begin
                        ch = any_byte();
                        send_item(ch, 1'b0);
                        if (ch == CH_QUOTE) send_item(CH_QUOTE, 1'b0);
                    end
                    send_item(CH_QUOTE, 1'b0);
                end
                default: ;
            endcase
        end
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                send_item(CH_CR, 1'b0);
                send_item(CH_LF, 1'b0);
            end
            4, 5, 6: send_item(CH_LF, 1'b0);
            7, 8:    send_item(CH_CR, 1'b0);
            default: send_end();
        endcase
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 5)) send_item(any_byte(), 1'b0);
        if ($urandom_range(0, 3) != 0) send_end();
    endtask

    task automatic test_plain_rows();
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(CH_COMMA, 1'b0);
        send_item("a", 1'b0);
        send_item(CH_LF, 1'b0);
        send_item(CH_CR, 1'b0);
        send_item(CH_LF, 1'b0);
        send_item(CH_LF, 1'b0);
    endtask

    task automatic test_quoted_fields();
        send_item(CH_QUOTE, 1'b0);
        send_item(CH_COMMA, 1'b0);
        send_item(CH_LF, 1'b0);
        send_item(CH_QUOTE, 1'b0);
        send_item(CH_QUOTE, 1'b0);
        send_item(CH_QUOTE, 1'b0);
        send_item(CH_CR, 1'b0);
        send_item(CH_LF, 1'b0);
        send_item(CH_QUOTE, 1'b0);
        send_item(CH_QUOTE, 1'b0);
        send_item(CH_COMMA, 1'b0);
        send_end();
    endtask

    task automatic test_error_cases();
        send_item("a", 1'b0);
        send_item(CH_QUOTE, 1'b0);
        send_item("x", 1'b0);
        send_end();
        send_item(CH_QUOTE, 1'b0);
        send_item(CH_QUOTE, 1'b0);
        send_item("z", 1'b0);
        send_end();
    endtask

    task automatic test_end_of_input();
        send_end();
        send_item(CH_QUOTE, 1'b0);
        send_item("q", 1'b0);
        send_end();
        send_item(CH_QUOTE, 1'b0);
        send_item(CH_QUOTE, 1'b0);
        send_end();
    endtask

    task automatic test_full_rate();
        src_idle_en = 1'b0;
        sink_idle_en <= 1'b0;
        repeat (12) send_record();
        src_idle_en = 1'b1;
        sink_idle_en <= 1'b1;
    endtask

    // Hold the receiver off while the sender keeps offering items.
    task automatic test_back_pressure();
        src_idle_en = 1'b0;
        hold_req <= ~hold_req;
        repeat (24) send_item(plain_byte(), 1'b0);
        send_item(CH_LF, 1'b0);
        src_idle_en = 1'b1;
    endtask

    task automatic test_random_records();
        while (items_sent < ITEM_TARGET) begin
            if ($urandom_range(0, 7) == 0) begin
                send_noise();
            end else begin
                send_record();
            end
        end
    endtask

    always @(posedge aclk) begin
        if (hold_req != hold_ack) begin
            m_tready <= 1'b0;
            if (hold_cnt == HOLD_CYCLES) begin
                hold_ack <= hold_req;
                hold_cnt <= 0;
            end else begin
                hold_cnt <= hold_cnt + 1;
            end
        end else if (sink_idle_en) begin
            m_tready <= ($urandom_range(0, 99) >= 25);
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : check_events
        token_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_tokens.size() == 0) begin
                report_fail($sformatf("unexpected event: kind=%0d data=%h", m_tuser, m_tdata));
            end else begin
                want = pending_tokens.pop_front();
                events_checked++;
                kind_count[want.kind]++;
                if (m_tuser !== want.kind || m_tdata[7:0] !== want.ch
                        || m_tdata[9:8] !== want.code || m_tdata[15:10] !== 6'd0) begin
                    report_fail({
                        $sformatf("event %0d: expected kind=%0d char=%h code=%0d, ",
                                  events_checked, want.kind, want.ch, want.code),
                        $sformatf("got kind=%0d char=%h code=%0d pad=%h",
                                  m_tuser, m_tdata[7:0], m_tdata[9:8], m_tdata[15:10])});
                end
            end
        end
    end

    initial begin
        int waited;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        clear_parser();

        test_plain_rows();
        test_quoted_fields();
        test_error_cases();
        test_end_of_input();
        test_full_rate();
        test_back_pressure();
        test_random_records();
        s_tvalid <= 1'b0;

        waited = 0;
        while (pending_tokens.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (8) @(posedge aclk);
        if (pending_tokens.size() != 0) begin
            report_fail($sformatf("%0d expected events never arrived", pending_tokens.size()));
        end

        $display("Sent %0d bytes and end markers; checked %0d events, %0d mismatches.",
                 items_sent, events_checked, fail_count);
        $display("Events by kind: %0d content, %0d field ends, %0d row ends, %0d errors.",
                 kind_count[EV_BYTE], kind_count[EV_FIELD], kind_count[EV_ROW],
                 kind_count[EV_ERROR]);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
